@@ rtl/psdh_pkg.sv @@
// Constants and types for the pseudo-DES hash pipeline.
package psdh_pkg;

    localparam int unsigned ROUNDS    = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned DATA_W    = 2 * WORD_W;
    localparam int unsigned KEY_COUNT = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HALF_W-1:0] t_half;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_word KEY_A [KEY_COUNT] = '{
        32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
    };
    localparam t_word KEY_B [KEY_COUNT] = '{
        32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
    };

endpackage

@@ rtl/psdh_in_if.sv @@
// Input beat channel: one 64-bit word to hash.
interface psdh_in_if;
    logic                   valid;
    logic                   ready;
    logic [psdh_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

@@ rtl/psdh_out_if.sv @@
// Output beat channel: one 64-bit hashed word.
interface psdh_out_if;
    logic                   valid;
    logic                   ready;
    logic [psdh_pkg::DATA_W-1:0] hash_out;

    modport source (output valid, output hash_out, input ready);
    modport sink   (input valid, input hash_out, output ready);
endinterface

@@ rtl/pseudo_des_hash.sv @@
// Pseudo-DES hash: pipelined Feistel rounds, one word in and one word out per beat.
//
// Channels: i_in carries data_in (upper 32 bits left half, lower 32 bits right
// half); o_out carries hash_out, left half in the upper 32 bits. A beat moves
// when valid and ready are both high on the rising edge of i_clk.
// Each round takes two register stages: the first XORs KEY_A into the right
// half and forms the three 16x16 products, the second does the two adds,
// half-word swap, KEY_B XOR and Feistel XOR. A beat passes through both
// stages of every round in turn. Throughput is one beat per cycle while
// o_out.ready is high; the three multipliers of a round set the stage depth.
// Each stage has its own valid bit and takes new data when it is empty or
// when the next stage takes its contents, so bubbles close up and a stalled
// output holds its beat while earlier stages keep filling. Nothing is lost
// or repeated across a stall.
// Reset (i_rst_n low, synchronous) clears all valid bits; the data registers
// are not reset.
module pseudo_des_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psdh_in_if.sink     i_in,
    psdh_out_if.source  o_out
);
    import psdh_pkg::*;

    t_word s_l [ROUNDS+1];
    t_word s_r [ROUNDS+1];
    logic  s_v [ROUNDS+1];
    logic  s_en [ROUNDS+1];

    assign s_l[0] = i_in.data_in[DATA_W-1:WORD_W];
    assign s_r[0] = i_in.data_in[WORD_W-1:0];
    assign s_v[0] = i_in.valid;
    assign i_in.ready = s_en[0];

    assign s_en[ROUNDS] = o_out.ready;

    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        localparam int unsigned KI = k % KEY_COUNT;

        logic  r_m_v;
        t_word r_m_keep;
        t_word r_m_left;
        t_word r_m_sq_lo;
        t_word r_m_sq_hi;
        t_word r_m_cross;
        logic  r_a_v;
        t_word r_a_l;
        t_word r_a_r;

        t_word w_t;
        t_half w_lo;
        t_half w_hi;
        t_word w_sq_lo;
        t_word w_sq_hi;
        t_word w_cross;
        t_word w_mix;
        t_word w_sw;
        t_word w_f;
        logic  w_en_m;
        logic  w_en_a;

        assign w_en_a = !r_a_v || s_en[k+1];
        assign w_en_m = !r_m_v || w_en_a;
        assign s_en[k] = w_en_m;

        assign w_t     = s_r[k] ^ KEY_A[KI];
        assign w_lo    = w_t[HALF_W-1:0];
        assign w_hi    = w_t[WORD_W-1:HALF_W];
        assign w_sq_lo = WORD_W'(w_lo) * WORD_W'(w_lo);
        assign w_sq_hi = WORD_W'(w_hi) * WORD_W'(w_hi);
        assign w_cross = WORD_W'(w_hi) * WORD_W'(w_lo);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_v <= 1'b0;
            end else if (w_en_m) begin
                r_m_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en_m) begin
                r_m_keep  <= s_r[k];
                r_m_left  <= s_l[k];
                r_m_sq_lo <= w_sq_lo;
                r_m_sq_hi <= w_sq_hi;
                r_m_cross <= w_cross;
            end
        end

        assign w_mix = r_m_sq_lo + ~r_m_sq_hi;
        assign w_sw  = {w_mix[HALF_W-1:0], w_mix[WORD_W-1:HALF_W]};
        assign w_f   = (w_sw ^ KEY_B[KI]) + r_m_cross;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v <= 1'b0;
            end else if (w_en_a) begin
                r_a_v <= r_m_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en_a) begin
                r_a_l <= r_m_keep;
                r_a_r <= r_m_left ^ w_f;
            end
        end

        assign s_l[k+1] = r_a_l;
        assign s_r[k+1] = r_a_r;
        assign s_v[k+1] = r_a_v;
    end

    assign o_out.valid    = s_v[ROUNDS];
    assign o_out.hash_out = {s_l[ROUNDS], s_r[ROUNDS]};

endmodule
